### rtl/timer_period_split_core_assert.svh
// Assertion macros shared by the timer period split RTL.
`ifndef TIMER_PERIOD_SPLIT_CORE_ASSERT_SVH
`define TIMER_PERIOD_SPLIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, held off during reset.
`define TPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer period split assertion failed");

// Next-cycle implication, sampled on clock, held off during reset.
`define TPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer period split assertion failed");

`endif

### rtl/tps_pkg.sv
// Types and constants shared by the timer period split modules.
package tps_pkg;

   localparam int unsigned CLK_W      = 26;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned PRE_W      = 8;
   localparam int unsigned PER_W      = 16;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned TICK_W     = 33;
   localparam int unsigned DIVISOR_W  = 17;
   localparam int unsigned DIV_CNT_W  = 6;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [DIVISOR_W-1:0]  MS_PER_SECOND      = 17'd1000;
   localparam logic [CLK_W-1:0]      BUS_CLOCK_RESET    = 26'd8000000;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUS_CLOCK_ADDR = 3'd0;
   localparam logic [DIV_CNT_W-1:0]  DIV_LAST_STEP      = 6'(TICK_W - 1);

   typedef enum logic [STATUS_W-1:0] {
      TPS_STATUS_OK      = 2'd0,
      TPS_STATUS_ZERO    = 2'd1,
      TPS_STATUS_NOSPLIT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      TPS_IDLE,
      TPS_SCALE,
      TPS_MUL,
      TPS_CHECK,
      TPS_TRIAL,
      TPS_FINISH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [TICK_W-1:0]    dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              rem_zero;
      logic [TICK_W-1:0] quotient;
   } div_stat_type;

endpackage

### rtl/timer_period_split_core.sv
// Top level of the timer period split: delay in milliseconds to prescale and period reloads.
//
// Each request transaction carries a delay in milliseconds. The block forms the tick count
// (bus_clock_hz / 1000) * delay_ms exactly, then tries prescale counts 1, 2, ... MAX_PRESCALE
// in turn and returns the first that divides the tick count exactly with a quotient of at most
// MAX_PERIOD, as prescale-minus-one and quotient-minus-one. A zero tick count gives status 1,
// and no usable prescale gives status 2, both with zero reload fields. One request is handled at
// a time; a new request is taken as soon as the previous result has been handed to the output
// register, so the result may wait there while the next request is worked on. All arithmetic is
// bit-serial through one shared 33-step restoring divider and a 16-step shift-and-add multiplier.
// The work runs in order through the scaling to kilohertz, the multiplication, a check of the tick
// count, one division for every prescale tried (up to MAX_PRESCALE trials, 256 by default) and
// the loading of the result into the output register.
`include "timer_period_split_core_assert.svh"

module timer_period_split_core #(
   parameter int unsigned MAX_PRESCALE = 256,
   parameter int unsigned MAX_PERIOD   = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel. tdata: delay_ms [15:0].
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tps_pkg::MS_W-1:0]             req_tdata,
   // Result channel. tdata: prescale_reload [7:0], period_reload [23:8].
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,
   // tuser: status [1:0].
   output logic [tps_pkg::STATUS_W-1:0]         rsp_tuser,
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tps_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tps_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import tps_pkg::*;

   localparam int unsigned TRIAL_W   = $clog2(MAX_PRESCALE + 1);
   localparam int unsigned MUL_CNT_W = $clog2(MS_W);
   localparam logic [TRIAL_W-1:0]   PRESCALE_LIMIT = TRIAL_W'(MAX_PRESCALE);
   localparam logic [TICK_W-1:0]    PERIOD_LIMIT   = TICK_W'(MAX_PERIOD);
   localparam logic [MUL_CNT_W-1:0] MUL_LAST       = MUL_CNT_W'(MS_W - 1);

   state_type            state_ff, state_in;
   logic [CLK_W-1:0]     bus_clock_ff, bus_clock_in;
   logic [MS_W-1:0]      mplier_ff, mplier_in;
   logic [TICK_W-1:0]    mcand_ff, mcand_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic [MUL_CNT_W-1:0] mul_cnt_ff, mul_cnt_in;
   logic [TRIAL_W-1:0]   trial_ff, trial_in;
   logic [PRE_W-1:0]     res_pre_ff, res_pre_in;
   logic [PER_W-1:0]     res_per_ff, res_per_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PRE_W-1:0]     rsp_pre_ff, rsp_pre_in;
   logic [PER_W-1:0]     rsp_per_ff, rsp_per_in;
   status_type           rsp_status_ff, rsp_status_in;

   div_req_type  div_req;
   div_stat_type div_stat;

   logic req_accept;
   logic csr_write;
   logic split_found;
   logic trials_spent;
   logic result_load;
   logic [TRIAL_W-1:0] trial_next;

   // Configuration transactions complete in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_BUS_CLOCK_ADDR) ? CSR_DATA_W'(bus_clock_ff) : '0;

   assign req_tready = (state_ff == TPS_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A trial succeeds when the division is exact and the period fits the channel counter.
   assign split_found  = div_stat.rem_zero && (div_stat.quotient <= PERIOD_LIMIT);
   assign trials_spent = (trial_ff == PRESCALE_LIMIT);
   assign trial_next   = trial_ff + 1'b1;
   assign result_load  = (state_ff == TPS_FINISH) && (!rsp_valid_ff || rsp_tready);

   tps_sdiv u_sdiv (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TPS_IDLE:   if (req_accept) state_in = TPS_SCALE;
         TPS_SCALE:  if (div_stat.done) state_in = TPS_MUL;
         TPS_MUL:    if (mul_cnt_ff == MUL_LAST) state_in = TPS_CHECK;
         TPS_CHECK:  state_in = (ticks_ff == '0) ? TPS_FINISH : TPS_TRIAL;
         TPS_TRIAL: begin
            if (div_stat.done && (split_found || trials_spent)) state_in = TPS_FINISH;
         end
         TPS_FINISH: if (result_load) state_in = TPS_IDLE;
         default:    state_in = TPS_IDLE;
      endcase
   end

   // Divider requests: the kilohertz scaling on acceptance, then one division per prescale.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = ticks_ff;
      div_req.divisor  = DIVISOR_W'(trial_ff);
      unique case (state_ff)
         TPS_IDLE: begin
            div_req.start    = req_accept;
            div_req.dividend = TICK_W'(bus_clock_ff);
            div_req.divisor  = MS_PER_SECOND;
         end
         TPS_CHECK: div_req.start = (ticks_ff != '0);
         TPS_TRIAL: begin
            div_req.start   = div_stat.done && !split_found && !trials_spent;
            div_req.divisor = DIVISOR_W'(trial_next);
         end
         default: div_req.start = 1'b0;
      endcase
   end

   // Datapath and result holding registers.
   always_comb begin
      bus_clock_in  = bus_clock_ff;
      mplier_in     = mplier_ff;
      mcand_in      = mcand_ff;
      ticks_in      = ticks_ff;
      mul_cnt_in    = mul_cnt_ff;
      trial_in      = trial_ff;
      res_pre_in    = res_pre_ff;
      res_per_in    = res_per_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pre_in    = rsp_pre_ff;
      rsp_per_in    = rsp_per_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write && csr_paddr == CSR_BUS_CLOCK_ADDR) begin
         bus_clock_in = csr_pwdata[CLK_W-1:0];
      end

      unique case (state_ff)
         TPS_IDLE: if (req_accept) mplier_in = req_tdata;
         TPS_SCALE: begin
            if (div_stat.done) begin
               mcand_in   = div_stat.quotient;
               ticks_in   = '0;
               mul_cnt_in = '0;
               trial_in   = TRIAL_W'(1);
            end
         end
         TPS_MUL: begin
            // Shift-and-add, one multiplier bit per cycle, least significant first.
            if (mplier_ff[0]) ticks_in = ticks_ff + mcand_ff;
            mcand_in   = {mcand_ff[TICK_W-2:0], 1'b0};
            mplier_in  = {1'b0, mplier_ff[MS_W-1:1]};
            mul_cnt_in = mul_cnt_ff + 1'b1;
         end
         TPS_CHECK: begin
            res_pre_in    = '0;
            res_per_in    = '0;
            res_status_in = TPS_STATUS_ZERO;
         end
         TPS_TRIAL: begin
            if (div_stat.done) begin
               if (split_found) begin
                  res_pre_in    = PRE_W'(trial_ff - 1'b1);
                  res_per_in    = PER_W'(div_stat.quotient - 1'b1);
                  res_status_in = TPS_STATUS_OK;
               end else if (trials_spent) begin
                  res_pre_in    = '0;
                  res_per_in    = '0;
                  res_status_in = TPS_STATUS_NOSPLIT;
               end else begin
                  trial_in = trial_next;
               end
            end
         end
         default: ;
      endcase

      if (result_load) begin
         rsp_valid_in  = 1'b1;
         rsp_pre_in    = res_pre_ff;
         rsp_per_in    = res_per_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TPS_IDLE;
         bus_clock_ff <= BUS_CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
         trial_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         bus_clock_ff <= bus_clock_in;
         rsp_valid_ff <= rsp_valid_in;
         trial_ff     <= trial_in;
      end
      mplier_ff     <= mplier_in;
      mcand_ff      <= mcand_in;
      ticks_ff      <= ticks_in;
      mul_cnt_ff    <= mul_cnt_in;
      res_pre_ff    <= res_pre_in;
      res_per_ff    <= res_per_in;
      res_status_ff <= res_status_in;
      rsp_pre_ff    <= rsp_pre_in;
      rsp_per_ff    <= rsp_per_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_per_ff, rsp_pre_ff};
   assign rsp_tuser  = rsp_status_ff;

   `TPS_ASSERT_NOW(a_trial_in_range, state_ff == TPS_TRIAL,
      trial_ff != '0 && trial_ff <= PRESCALE_LIMIT)
   `TPS_ASSERT_NOW(a_div_done_expected, div_stat.done,
      state_ff == TPS_SCALE || state_ff == TPS_TRIAL)
   `TPS_ASSERT_NEXT(a_result_from_finish, result_load,
      rsp_valid_ff && $past(state_ff) == TPS_FINISH && state_ff == TPS_IDLE)

endmodule

### rtl/tps_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`include "timer_period_split_core_assert.svh"

module tps_sdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  tps_pkg::div_req_type req,
   output tps_pkg::div_stat_type stat
);
   import tps_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TICK_W-1:0]    num_ff, num_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W:0]   shifted;
   logic                 fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign shifted = {rem_ff, num_ff[TICK_W-1]};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start && !busy_ff) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         num_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[TICK_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(shifted - {1'b0, divisor_ff}) : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.quotient = num_ff;

   `TPS_ASSERT_NOW(a_start_when_free, req.start, !busy_ff)
   `TPS_ASSERT_NEXT(a_done_after_last, busy_ff && cnt_ff == DIV_LAST_STEP, done_ff && !busy_ff)
   `TPS_ASSERT_NOW(a_rem_below_divisor, done_ff && divisor_ff != '0, rem_ff < divisor_ff)

endmodule
